>>> sv/irpd_pkg.sv
`timescale 1ns / 1ps
// Package for the IR pulse-distance decoder: register indexes, reset values,
// field widths and the configuration and result types. No dependencies.
package irpd_pkg;

  localparam int INTERVAL_W = 16;
  localparam int CMD_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int POS_CMP_W  = 8;

  localparam int FRAME_EDGES_DEF    = 68;
  localparam int FIRST_DATA_POS_DEF = 34;

  localparam logic [INTERVAL_W-1:0] GAP_THRESHOLD_RST = 16'd20000;
  localparam logic [INTERVAL_W-1:0] LEADER_MIN_RST    = 16'd11000;
  localparam logic [INTERVAL_W-1:0] LEADER_MAX_RST    = 16'd15000;
  localparam logic [INTERVAL_W-1:0] ONE_MIN_RST       = 16'd1800;
  localparam logic [INTERVAL_W-1:0] ONE_MAX_RST       = 16'd3000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAP_THRESHOLD = 3'd0,
    REG_LEADER_MIN    = 3'd1,
    REG_LEADER_MAX    = 3'd2,
    REG_ONE_MIN       = 3'd3,
    REG_ONE_MAX       = 3'd4
  } irpd_reg_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] gap_threshold;
    logic [INTERVAL_W-1:0] leader_min;
    logic [INTERVAL_W-1:0] leader_max;
    logic [INTERVAL_W-1:0] one_min;
    logic [INTERVAL_W-1:0] one_max;
  } irpd_cfg_t;

  typedef struct packed {
    logic             frame_done;
    logic             leader_ok;
    logic [CMD_W-1:0] command;
  } irpd_result_t;

endpackage

>>> sv/irpd_core.sv
`timescale 1ns / 1ps
// Frame tracking for the IR decoder: edge position, leader check and command
// bits, updated once per accepted interval. Depends on irpd_pkg.
module irpd_core #(
  parameter int FRAME_EDGES    = irpd_pkg::FRAME_EDGES_DEF,
  parameter int FIRST_DATA_POS = irpd_pkg::FIRST_DATA_POS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [irpd_pkg::INTERVAL_W-1:0] interval_us,
  input  irpd_pkg::irpd_cfg_t             cfg,
  output irpd_pkg::irpd_result_t          result
);
  import irpd_pkg::*;

  localparam int PW = $clog2(FRAME_EDGES);
  localparam logic [PW-1:0]        LEADER_POS = PW'(1);
  localparam logic [PW-1:0]        LAST_POS   = PW'(FRAME_EDGES - 1);
  localparam logic [POS_CMP_W-1:0] FIRST_L    = POS_CMP_W'(FIRST_DATA_POS);
  localparam logic [POS_CMP_W-1:0] END_L      = POS_CMP_W'(FIRST_DATA_POS + CMD_W);

  logic [PW-1:0]    pos_r, pos_nxt, pos_cur;
  logic             leader_r, leader_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [POS_CMP_W-1:0] pos_ext, bit_off;
  logic             is_one, in_leader_win, done;

  always_comb begin
    pos_cur       = (interval_us > cfg.gap_threshold) ? '0 : pos_r;
    pos_ext       = POS_CMP_W'(pos_cur);
    bit_off       = pos_ext - FIRST_L;
    is_one        = (interval_us >= cfg.one_min) && (interval_us <= cfg.one_max);
    in_leader_win = (interval_us >= cfg.leader_min) && (interval_us <= cfg.leader_max);
    done          = (pos_cur == LAST_POS);

    leader_nxt = leader_r;
    if (pos_cur == LEADER_POS) begin
      leader_nxt = in_leader_win;
    end
    cmd_nxt = cmd_r;
    if ((pos_ext >= FIRST_L) && (pos_ext < END_L)) begin
      cmd_nxt[bit_off[2:0]] = is_one;
    end
    pos_nxt = done ? '0 : pos_cur + PW'(1);

    result.frame_done = done;
    result.leader_ok  = done && leader_nxt;
    result.command    = (done && leader_nxt) ? cmd_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      leader_r <= 1'b0;
      cmd_r    <= '0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      leader_r <= leader_nxt;
      cmd_r    <= cmd_nxt;
    end
  end

endmodule

>>> sv/ir_pulse_distance_decoder_top.sv
`timescale 1ns / 1ps
// Top level of the IR pulse-distance decoder: configuration registers,
// frame tracking core and a two-entry output stage. Depends on irpd_pkg, irpd_core.
//
// Usage:
//   Each input beat carries one edge-to-edge interval in microseconds on
//   in_tdata. Every input beat produces exactly one output beat. out_tlast
//   is high on the beat that completes a frame; out_tuser then gives the
//   leader check and out_tdata the command byte (zero when the leader failed
//   or no frame was completed).
//   An accepted beat's result is registered in the result register, or in the
//   skid entry while the receiver stalls. Throughput is one beat per cycle
//   when the receiver does not stall; the core's compare logic is combinational.
//   The output stage holds a result register and one skid entry, so a new
//   beat is taken while a result still waits. When the receiver stalls,
//   in_tready falls once both entries are full and rises again after the
//   receiver takes a beat. in_tready comes straight from a register.
//   Reset clears the frame position, leader flag and command bits, empties
//   the output stage and loads the register reset values. Configuration is
//   written by the user through cfg_we, cfg_index and cfg_data while the block
//   is idle, not enforced by the block; writes past the last index are ignored.
module ir_pulse_distance_decoder_top #(
  parameter int FRAME_EDGES    = irpd_pkg::FRAME_EDGES_DEF,
  parameter int FIRST_DATA_POS = irpd_pkg::FIRST_DATA_POS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [irpd_pkg::INTERVAL_W-1:0] in_tdata,   // [15:0] interval_us
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [irpd_pkg::CMD_W-1:0]      out_tdata,  // [7:0] command
  output logic                            out_tlast,  // frame_done
  output logic                            out_tuser,  // [0] leader_ok
  input  logic                            cfg_we,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irpd_pkg::INTERVAL_W-1:0] cfg_data
);
  import irpd_pkg::*;

  irpd_cfg_t    cfg_r;
  irpd_result_t rslt;
  irpd_result_t out_r, skid_r;
  logic         out_valid_r, skid_valid_r;
  logic         accept;

  assign in_tready  = !skid_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_r.frame_done;
  assign out_tuser  = out_r.leader_ok;
  assign out_tdata  = out_r.command;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gap_threshold <= GAP_THRESHOLD_RST;
      cfg_r.leader_min    <= LEADER_MIN_RST;
      cfg_r.leader_max    <= LEADER_MAX_RST;
      cfg_r.one_min       <= ONE_MIN_RST;
      cfg_r.one_max       <= ONE_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAP_THRESHOLD: cfg_r.gap_threshold <= cfg_data;
        REG_LEADER_MIN:    cfg_r.leader_min    <= cfg_data;
        REG_LEADER_MAX:    cfg_r.leader_max    <= cfg_data;
        REG_ONE_MIN:       cfg_r.one_min       <= cfg_data;
        REG_ONE_MAX:       cfg_r.one_max       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  irpd_core #(
    .FRAME_EDGES    (FRAME_EDGES),
    .FIRST_DATA_POS (FIRST_DATA_POS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .interval_us (in_tdata),
    .cfg         (cfg_r),
    .result      (rslt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_r       <= rslt;
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_r       <= rslt;
      skid_valid_r <= 1'b1;
    end
  end

endmodule
